// ===== hdl/quoted_command_line_tokenizer_defines.svh =====
// assertion macros used by the tokenizer checker
`ifndef QUOTED_COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define QUOTED_COMMAND_LINE_TOKENIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define QCLT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication, sampled on clk, off during reset
`define QCLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ===== hdl/qclt_pkg.sv =====
// types and constants of the command-line tokenizer
package qclt_pkg;

    localparam int QCLT_LEN_W = 10;
    localparam logic [QCLT_LEN_W-1:0] QCLT_MAX_LEN_RESET = 10'd1023;

    localparam int QCLT_Q_DEPTH = 4;
    localparam int QCLT_Q_PTR_W = $clog2(QCLT_Q_DEPTH);
    localparam int QCLT_Q_CNT_W = $clog2(QCLT_Q_DEPTH + 1);

    localparam logic [7:0] QCLT_CH_SPACE  = 8'h20;
    localparam logic [7:0] QCLT_CH_TAB    = 8'h09;
    localparam logic [7:0] QCLT_CH_DQUOTE = 8'h22;
    localparam logic [7:0] QCLT_CH_SQUOTE = 8'h27;
    localparam logic [7:0] QCLT_CH_BSLASH = 8'h5C;
    localparam logic [7:0] QCLT_CH_LOW_R  = 8'h72;
    localparam logic [7:0] QCLT_CH_LOW_N  = 8'h6E;
    localparam logic [7:0] QCLT_CH_LOW_T  = 8'h74;
    localparam logic [7:0] QCLT_CH_CR     = 8'h0D;
    localparam logic [7:0] QCLT_CH_LF     = 8'h0A;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_BARE = 4'b0010,
        MODE_DQ   = 4'b0100,
        MODE_SQ   = 4'b1000
    } qclt_mode_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] chr;
    } qclt_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       word_end;
    } qclt_out_t;

    typedef struct packed {
        logic [1:0] count;
        qclt_out_t  item0;
        qclt_out_t  item1;
    } qclt_push_t;

endpackage

// ===== hdl/quoted_command_line_tokenizer.sv =====
// top level of the quoted command-line tokenizer
//
// char channel: char_valid/char_ready with char_item (cmd, chr); one request is either
// a line character or an end-of-line mark. tok channel: tok_valid/tok_ready with
// tok_item (out_char, has_char, word_end); each request gives zero, one or two results.
// cfg channel: cfg_valid/cfg_ready with cfg_data, the maximum word length; cfg_ready
// is always high and the value takes effect from the next request.
// results are registered: a request's results are written into the output queue.
// throughput: one request per cycle while char_ready is high; state update and result
// decision are combinational logic, and results land in a four-entry output queue.
// char_ready drops while the queue holds more than two results, so a request that
// gives two results never finds the queue short of room.
// when the receiver stalls the queue fills and requests are held off; nothing is lost.
// reset empties the queue, returns the tokenizer to idle between words and sets the
// maximum word length to 1023.
module quoted_command_line_tokenizer
    import qclt_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_ready,
    input  qclt_in_t              char_item,
    output logic                  tok_valid,
    input  logic                  tok_ready,
    output qclt_out_t             tok_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [QCLT_LEN_W-1:0] cfg_data
);

    logic [QCLT_LEN_W-1:0] max_len_reg;
    logic [QCLT_LEN_W-1:0] max_len_next;
    logic                  fire;
    logic                  space_ok;
    qclt_push_t            push;

    assign cfg_ready    = 1'b1;
    assign max_len_next = (cfg_valid && cfg_ready) ? cfg_data : max_len_reg;
    assign char_ready   = space_ok;
    assign fire         = char_valid && char_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg <= QCLT_MAX_LEN_RESET;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    qclt_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .req     (char_item),
        .max_len (max_len_reg),
        .push    (push)
    );

    qclt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

endmodule

// ===== hdl/qclt_step.sv =====
// tokenizer state and per-request decision logic
module qclt_step
    import qclt_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  qclt_in_t              req,
    input  logic [QCLT_LEN_W-1:0] max_len,
    output qclt_push_t            push
);

    localparam int LW = (COUNT_WIDTH > QCLT_LEN_W) ? COUNT_WIDTH : QCLT_LEN_W;

    typedef struct packed {
        qclt_mode_t             mode;
        logic                   esc;
        logic [COUNT_WIDTH-1:0] wc;
    } tk_state_t;

    typedef struct packed {
        tk_state_t st;
        qclt_out_t res;
        logic      res_valid;
        logic      again;
    } pass_t;

    localparam tk_state_t IDLE_ST = '{mode: MODE_IDLE, esc: 1'b0, wc: '0};
    localparam qclt_out_t END_ONLY = '{out_char: 8'h00, has_char: 1'b0, word_end: 1'b1};

    tk_state_t     st_reg;
    tk_state_t     st_next;
    tk_state_t     st_after;
    pass_t         p1;
    pass_t         p2;
    qclt_push_t    push_all;
    logic [LW-1:0] lim;

    function automatic pass_t single_pass(tk_state_t s, logic [7:0] c, logic [LW-1:0] l);
        pass_t                  p;
        logic [7:0]             q;
        logic [7:0]             ec;
        logic                   emit_c;
        logic                   at_end;
        logic [COUNT_WIDTH-1:0] w1;
        p.st = s;
        p.res = '0;
        p.res_valid = 1'b0;
        p.again = 1'b0;
        emit_c = 1'b0;
        ec = c;
        q = (s.mode == MODE_DQ) ? QCLT_CH_DQUOTE : QCLT_CH_SQUOTE;
        unique case (s.mode)
            MODE_IDLE:
            begin
                if (c == QCLT_CH_SPACE || c == QCLT_CH_TAB) begin
                end else if (c == QCLT_CH_DQUOTE) begin
                    p.st.mode = MODE_DQ;
                end else if (c == QCLT_CH_SQUOTE) begin
                    p.st.mode = MODE_SQ;
                end else begin
                    p.st.mode = MODE_BARE;
                    emit_c = 1'b1;
                end
            end
            MODE_BARE:
            begin
                if (c == QCLT_CH_SPACE || c == QCLT_CH_TAB) begin
                    p.st = IDLE_ST;
                    p.res = END_ONLY;
                    p.res_valid = 1'b1;
                end else if (c == QCLT_CH_DQUOTE) begin
                    // word ends and the quote opens a new one
                    p.st = IDLE_ST;
                    p.st.mode = MODE_DQ;
                    p.res = END_ONLY;
                    p.res_valid = 1'b1;
                end else begin
                    emit_c = 1'b1;
                end
            end
            MODE_DQ, MODE_SQ:
            begin
                if (s.esc) begin
                    p.st.esc = 1'b0;
                    emit_c = 1'b1;
                    if (c == q || c == QCLT_CH_BSLASH) begin
                        ec = c;
                    end else if (c == QCLT_CH_LOW_R) begin
                        ec = QCLT_CH_CR;
                    end else if (c == QCLT_CH_LOW_N) begin
                        ec = QCLT_CH_LF;
                    end else if (c == QCLT_CH_LOW_T) begin
                        ec = QCLT_CH_TAB;
                    end else begin
                        // kept backslash, the character is taken again
                        ec = QCLT_CH_BSLASH;
                        p.again = 1'b1;
                    end
                end else if (c == q) begin
                    p.st = IDLE_ST;
                    p.res = END_ONLY;
                    p.res_valid = 1'b1;
                end else if (c == QCLT_CH_BSLASH) begin
                    p.st.esc = 1'b1;
                end else begin
                    emit_c = 1'b1;
                end
            end
            default:
            begin
                p.st = IDLE_ST;
            end
        endcase
        w1 = p.st.wc + COUNT_WIDTH'(1);
        at_end = (LW'(w1) >= l);
        if (emit_c) begin
            p.st.wc = w1;
            p.res = '{out_char: ec, has_char: 1'b1, word_end: at_end};
            p.res_valid = 1'b1;
            if (at_end) begin
                p.st = IDLE_ST;
            end
        end
        return p;
    endfunction

    always_comb
    begin
        lim = LW'(max_len);
        if (lim == '0) begin
            lim = LW'(1);
        end
        if (lim > LW'({COUNT_WIDTH{1'b1}})) begin
            lim = LW'({COUNT_WIDTH{1'b1}});
        end
    end

    assign p1 = single_pass(st_reg, req.chr, lim);
    assign p2 = single_pass(p1.st, req.chr, lim);

    always_comb
    begin
        push_all.item0 = p1.res;
        push_all.item1 = p2.res;
        if (req.cmd) begin
            st_after = IDLE_ST;
            push_all.item0 = END_ONLY;
            push_all.count = {1'b0, st_reg.mode != MODE_IDLE};
        end else begin
            st_after = p1.again ? p2.st : p1.st;
            push_all.count = {1'b0, p1.res_valid} + {1'b0, p1.again & p2.res_valid};
        end
    end

    always_comb
    begin
        push = push_all;
        if (!fire) begin
            push.count = 2'd0;
        end
        st_next = fire ? st_after : st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= IDLE_ST;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== hdl/qclt_outq.sv =====
// result queue taking up to two results per cycle
module qclt_outq
    import qclt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qclt_push_t push,
    output logic       space_ok,
    output logic       tok_valid,
    input  logic       tok_ready,
    output qclt_out_t  tok_item
);

    qclt_out_t               mem_reg [QCLT_Q_DEPTH];
    logic [QCLT_Q_PTR_W-1:0] rd_ptr_reg;
    logic [QCLT_Q_PTR_W-1:0] rd_ptr_next;
    logic [QCLT_Q_PTR_W-1:0] wr_ptr_reg;
    logic [QCLT_Q_PTR_W-1:0] wr_ptr_next;
    logic [QCLT_Q_PTR_W-1:0] wr_ptr_inc;
    logic [QCLT_Q_CNT_W-1:0] cnt_reg;
    logic [QCLT_Q_CNT_W-1:0] cnt_next;
    logic                    pop;

    assign tok_valid  = (cnt_reg != '0);
    assign tok_item   = mem_reg[rd_ptr_reg];
    assign pop        = tok_valid && tok_ready;
    assign space_ok   = (cnt_reg <= QCLT_Q_CNT_W'(QCLT_Q_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + QCLT_Q_PTR_W'(1);

    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + QCLT_Q_PTR_W'(1) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + QCLT_Q_PTR_W'(push.count);
        cnt_next    = cnt_reg + QCLT_Q_CNT_W'(push.count) - QCLT_Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.item1;
        end
    end

endmodule

// ===== hdl/qclt_check.sv =====
// port-level checker for the tokenizer and its bind
`include "quoted_command_line_tokenizer_defines.svh"

module qclt_check
    import qclt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      char_ready,
    input logic      tok_valid,
    input logic      tok_ready,
    input qclt_out_t tok_item
);

    logic end_only;

    assign end_only = tok_item.word_end && (tok_item.out_char == 8'h00);

    `QCLT_ASSERT_NOW(a_bare_end, tok_valid && !tok_item.has_char, end_only)
    `QCLT_ASSERT_NOW(a_empty_ready, !tok_valid, char_ready)
    `QCLT_ASSERT_NEXT(a_tok_hold, tok_valid && !tok_ready, tok_valid)
    `QCLT_ASSERT_NEXT(a_tok_stable, tok_valid && !tok_ready, $stable(tok_item))

endmodule

bind quoted_command_line_tokenizer qclt_check u_qclt_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_ready (char_ready),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok_item   (tok_item)
);
